// ===== design/vertex_dedup_tolerance_table_macros.svh =====
// assertion macros used by the vertex dedup table search engine (vdtt_back)
`ifndef VERTEX_DEDUP_TOLERANCE_TABLE_MACROS_SVH
`define VERTEX_DEDUP_TOLERANCE_TABLE_MACROS_SVH

// same-cycle implication, checked on clk, off during rst
`define VDTT_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during rst
`define VDTT_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== design/vdtt_pkg.sv =====
// shared constants, types and match functions for the vertex dedup table
`timescale 1ns / 1ps

package vdtt_pkg;

  localparam int MAX_UNIQUE = 1024;
  localparam int NCOMP      = 8;
  localparam int COMP_W     = 32;
  localparam int IDX_W      = $clog2(MAX_UNIQUE);
  localparam int CNT_W      = $clog2(MAX_UNIQUE + 1);
  localparam int TOL_W      = 16;
  localparam int OUT_IDX_W  = 10;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_UNIQUE);
  localparam logic [QCNT_W-1:0] QFULL_CNT = QCNT_W'(QDEPTH);
  localparam logic [TOL_W-1:0]  TOL_RESET = 16'd2;

  typedef logic [NCOMP-1:0][COMP_W-1:0] vertex_t;

  typedef struct packed {
    logic    new_mesh;
    vertex_t vtx;
  } item_t;

  // |a - b| < tol, difference taken one bit wider so it cannot wrap
  function automatic logic comp_close(input logic [COMP_W-1:0] a,
                                      input logic [COMP_W-1:0] b,
                                      input logic [TOL_W-1:0]  tol);
    logic [COMP_W:0] diff;
    logic [COMP_W:0] mag;
    diff = {a[COMP_W-1], a} - {b[COMP_W-1], b};
    mag  = diff[COMP_W] ? (~diff + 1'b1) : diff;
    return mag < {{(COMP_W + 1 - TOL_W){1'b0}}, tol};
  endfunction

  function automatic logic vertex_match(input vertex_t a, input vertex_t b,
                                        input logic [TOL_W-1:0] tol);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < NCOMP; k++) begin
      ok = ok & comp_close(a[k], b[k], tol);
    end
    return ok;
  endfunction

endpackage

// ===== design/vdtt_front.sv =====
// input side: accepts items into a short queue ahead of the search engine
`timescale 1ns / 1ps

module vdtt_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  vdtt_pkg::item_t in_item,
  output logic           q_valid,
  output vdtt_pkg::item_t q_item,
  input  logic           q_pop
);

  vdtt_pkg::item_t                   qmem [vdtt_pkg::QDEPTH];
  logic [vdtt_pkg::QPTR_W-1:0]       wr_ptr;
  logic [vdtt_pkg::QPTR_W-1:0]       rd_ptr;
  logic [vdtt_pkg::QCNT_W-1:0]       qcnt;
  logic                              push;

  assign in_stall = (qcnt == vdtt_pkg::QFULL_CNT);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (qcnt != '0);
  assign q_item   = qmem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      qcnt   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !q_pop) begin
        qcnt <= qcnt + 1'b1;
      end else if (!push && q_pop) begin
        qcnt <= qcnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) qmem[wr_ptr] <= in_item;
  end

endmodule

// ===== design/vdtt_back.sv =====
// search engine: walks the unique table, appends misses while it has room, holds the result
`timescale 1ns / 1ps
`include "vertex_dedup_tolerance_table_macros.svh"

module vdtt_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [vdtt_pkg::TOL_W-1:0]     tolerance,
  input  logic                           q_valid,
  input  vdtt_pkg::item_t                q_item,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [vdtt_pkg::OUT_IDX_W-1:0] unique_index,
  output logic                           is_new,
  output logic                           overflow
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  vdtt_pkg::vertex_t               mem [vdtt_pkg::MAX_UNIQUE];
  vdtt_pkg::vertex_t               rd_data;
  vdtt_pkg::vertex_t               cur;
  logic [1:0]                      state;
  logic [vdtt_pkg::CNT_W-1:0]      count;
  logic [vdtt_pkg::CNT_W-1:0]      rd_idx;
  logic [vdtt_pkg::IDX_W-1:0]      cmp_idx;
  logic                            cmp_vld;
  logic [vdtt_pkg::IDX_W-1:0]      res_idx;
  logic                            res_new;
  logic                            res_ovf;
  logic                            rd_en;
  logic                            hit;
  logic                            miss;
  logic                            app_en;
  logic                            out_load;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign rd_en    = (state == S_SEARCH) && (rd_idx < count);
  assign hit      = (state == S_SEARCH) && cmp_vld
                    && vdtt_pkg::vertex_match(cur, rd_data, tolerance);
  // last read issued and its compare (if any) came back empty
  assign miss     = (state == S_SEARCH) && !rd_en && !hit;
  assign app_en   = miss && (count != vdtt_pkg::MAX_CNT);
  assign out_load = (state == S_FINISH) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cmp_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cmp_vld <= rd_en;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.new_mesh) count <= '0;
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (hit) begin
            state <= S_FINISH;
          end else if (miss) begin
            if (app_en) count <= count + 1'b1;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur    <= q_item.vtx;
      rd_idx <= '0;
    end else if (rd_en) begin
      rd_idx <= rd_idx + 1'b1;
    end
    cmp_idx <= rd_idx[vdtt_pkg::IDX_W-1:0];
    if (hit) begin
      res_idx <= cmp_idx;
      res_new <= 1'b0;
      res_ovf <= 1'b0;
    end else if (app_en) begin
      res_idx <= count[vdtt_pkg::IDX_W-1:0];
      res_new <= 1'b1;
      res_ovf <= 1'b0;
    end else if (miss) begin
      res_idx <= '0;
      res_new <= 1'b0;
      res_ovf <= 1'b1;
    end
    if (out_load) begin
      unique_index <= res_idx[vdtt_pkg::OUT_IDX_W-1:0];
      is_new       <= res_new;
      overflow     <= res_ovf;
    end
  end

  // unique table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (app_en) mem[count[vdtt_pkg::IDX_W-1:0]] <= cur;
    if (rd_en) rd_data <= mem[rd_idx[vdtt_pkg::IDX_W-1:0]];
  end

  `VDTT_ASSERT_IMP(a_count_bound, 1'b1, count <= vdtt_pkg::MAX_CNT, "entry count past table size")
  `VDTT_ASSERT_NXT(a_append_count, app_en, count == $past(count) + 1'b1, "append lost count")
  `VDTT_ASSERT_IMP(a_hit_in_table, hit, cmp_idx < count, "match on entry beyond fill")
  `VDTT_ASSERT_NXT(a_finish_loads, out_load, out_valid && state == S_IDLE, "result not loaded")

endmodule

// ===== design/vertex_dedup_tolerance_table.sv =====
// Vertex dedup table with per-component tolerance.
//
// Input channel: in_valid / in_stall carry one vertex per item (new_mesh and
// eight signed Q12.20 components). An item is taken on a clock edge with
// in_valid high and in_stall low; a two-entry queue sits in front of the
// search engine, so up to two items are taken while a search runs.
// Output channel: out_valid / out_stall carry unique_index, is_new and
// overflow, one result item per vertex, in input order. The result sits in an
// output register that holds while out_stall is high; the engine goes on to
// the next queued vertex and waits only when it has a new result to load.
// Search: the engine reads one stored entry per cycle from the table memory
// (one registered read port), stops at the first match or after the last
// stored entry on a miss, so the time per vertex grows with the table fill;
// it takes the next vertex only once the current result is loaded.
// match_tolerance is written with cfg_we / cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Reset (rst, synchronous): empties the queue and the table, drops any pending
// result and sets match_tolerance to 2. No clearing pass is needed.
`timescale 1ns / 1ps

module vertex_dedup_tolerance_table (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [vdtt_pkg::TOL_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           new_mesh,
  input  logic signed [31:0]             pos_x,
  input  logic signed [31:0]             pos_y,
  input  logic signed [31:0]             pos_z,
  input  logic signed [31:0]             tex_u,
  input  logic signed [31:0]             tex_v,
  input  logic signed [31:0]             norm_x,
  input  logic signed [31:0]             norm_y,
  input  logic signed [31:0]             norm_z,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [vdtt_pkg::OUT_IDX_W-1:0] unique_index,
  output logic                           is_new,
  output logic                           overflow
);

  logic [vdtt_pkg::TOL_W-1:0] match_tolerance;
  vdtt_pkg::item_t            in_item;
  vdtt_pkg::item_t            q_item;
  logic                       q_valid;
  logic                       q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_tolerance <= vdtt_pkg::TOL_RESET;
    end else if (cfg_we) begin
      match_tolerance <= cfg_wdata;
    end
  end

  always_comb begin
    in_item.new_mesh = new_mesh;
    in_item.vtx[0]   = pos_x;
    in_item.vtx[1]   = pos_y;
    in_item.vtx[2]   = pos_z;
    in_item.vtx[3]   = tex_u;
    in_item.vtx[4]   = tex_v;
    in_item.vtx[5]   = norm_x;
    in_item.vtx[6]   = norm_y;
    in_item.vtx[7]   = norm_z;
  end

  vdtt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  vdtt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .tolerance    (match_tolerance),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .unique_index (unique_index),
    .is_new       (is_new),
    .overflow     (overflow)
  );

endmodule
